FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define AST_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assertion on the block clock and reset.
`define AST_DEF(lbl, prop) `AST_CLK(lbl, aclk, aresetn, prop)

`endif

FILE: rtl/core/cba_pkg.sv
package cba_pkg;

    localparam int DISK_BLOCKS = 256;
    localparam int ADDR_W      = $clog2(DISK_BLOCKS);
    localparam int CNT_W       = $clog2(DISK_BLOCKS + 1);
    localparam int TAG_W       = 8;
    localparam int ENTRY_W     = TAG_W + 1;

    localparam logic [TAG_W-1:0] FREE_TAG        = 8'd95;
    localparam logic [8:0]       DISK_SIZE_RESET = 9'd256;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_PLACE  = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_PLACE  = 2'd1,
        MODE_DELETE = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] file_tag;
        logic [8:0] block_count;
        logic [7:0] start_block;
    } cba_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] first_block_out;
        logic [8:0] freed_count;
    } cba_rsp_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       claim_start;
        logic       status_we;
        logic [1:0] status_code;
        logic       emit;
    } cba_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       len_zero;
        logic       place_in_range;
        logic       scan_done;
        logic       scan_ok;
        logic       claim_done;
        logic       out_free;
    } cba_sts_t;

endpackage

FILE: rtl/core/cba_ram.sv
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/cba_datapath.sv
module cba_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  cba_pkg::cba_req_t s_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [8:0]        cfg_data,
    input  cba_pkg::cba_cmd_t cmd,
    output cba_pkg::cba_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output cba_pkg::cba_rsp_t m_data
);

    import cba_pkg::*;

    logic [8:0]             disk_size_reg, disk_size_next;
    logic [CNT_W-1:0]       eff_size;
    cba_req_t               req_reg, req_next;
    scan_mode_t             mode_reg, mode_next;
    logic                   scanning_reg, scanning_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic                   p_vld_reg, p_vld_next;
    logic [ADDR_W-1:0]      p_idx_reg, p_idx_next;
    logic [CNT_W-1:0]       run_reg, run_next;
    logic [CNT_W-1:0]       run_start_reg, run_start_next;
    logic                   claiming_reg, claiming_next;
    logic [CNT_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]       wr_end_reg, wr_end_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [7:0]             res_first_reg, res_first_next;
    logic [8:0]             res_freed_reg, res_freed_next;
    logic                   m_valid_reg, m_valid_next;
    cba_rsp_t               m_data_reg, m_data_next;
    logic [DISK_BLOCKS-1:0] ent_vld_reg, ent_vld_next;
    logic                   rd_vld_reg, rd_vld_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic                   ent_used;
    logic [TAG_W-1:0]       ent_tag;
    logic [CNT_W-1:0]       run_inc;
    logic                   create_hit, place_hit, del_match;
    logic                   issue, exhausted, scan_done, claim_done;
    logic [CNT_W:0]         place_end;
    logic [CNT_W-1:0]       claim_base;

    cba_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DISK_BLOCKS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign eff_size  = (disk_size_reg > 9'(DISK_BLOCKS)) ? CNT_W'(DISK_BLOCKS)
                                                         : CNT_W'(disk_size_reg);
    assign place_end = (CNT_W + 1)'(req_reg.start_block)
                     + (CNT_W + 1)'(req_reg.block_count);

    // An entry never written reads as a free block with the free tag.
    assign ent_used = rd_vld_reg & ram_rdata[TAG_W];
    assign ent_tag  = rd_vld_reg ? ram_rdata[TAG_W-1:0] : FREE_TAG;
    assign run_inc  = run_reg + CNT_W'(1);

    assign create_hit = p_vld_reg && (mode_reg == MODE_CREATE) && !ent_used
                     && (run_inc == CNT_W'(req_reg.block_count));
    assign place_hit  = p_vld_reg && (mode_reg == MODE_PLACE) && ent_used;
    assign del_match  = p_vld_reg && (mode_reg == MODE_DELETE) && ent_used
                     && (ent_tag == req_reg.file_tag);
    assign issue      = scanning_reg && (rd_idx_reg < limit_reg);
    assign exhausted  = scanning_reg && !p_vld_reg && (rd_idx_reg >= limit_reg);
    assign scan_done  = scanning_reg && (create_hit || place_hit || exhausted);
    assign claim_done = claiming_reg && ((wr_idx_reg + CNT_W'(1)) == wr_end_reg);
    assign claim_base = (mode_reg == MODE_PLACE) ? CNT_W'(req_reg.start_block)
                                                 : run_start_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p_idx_reg;
        ram_wdata = {1'b0, FREE_TAG};
        if (claiming_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wr_idx_reg[ADDR_W-1:0];
            ram_wdata = {1'b1, req_reg.file_tag};
        end else if (del_match) begin
            ram_we    = 1'b1;
        end
    end

    always_comb begin
        sts.action         = req_reg.action;
        sts.len_zero       = (req_reg.block_count == 9'd0);
        sts.place_in_range = (place_end <= (CNT_W + 1)'(eff_size));
        sts.scan_done      = scan_done;
        sts.scan_ok        = create_hit || ((mode_reg == MODE_PLACE) && !place_hit);
        sts.claim_done     = claim_done;
        sts.out_free       = !m_valid_reg || m_ready;
    end

    always_comb begin
        disk_size_next  = disk_size_reg;
        req_next        = req_reg;
        mode_next       = mode_reg;
        scanning_next   = scanning_reg;
        rd_idx_next     = rd_idx_reg;
        limit_next      = limit_reg;
        p_vld_next      = 1'b0;
        p_idx_next      = rd_idx_reg[ADDR_W-1:0];
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        claiming_next   = claiming_reg;
        wr_idx_next     = wr_idx_reg;
        wr_end_next     = wr_end_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_freed_next  = res_freed_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ent_vld_next    = ent_vld_reg;
        rd_vld_next     = ent_vld_reg[rd_idx_reg[ADDR_W-1:0]];

        if (cfg_valid) begin
            disk_size_next = cfg_data;
        end

        if (cmd.load) begin
            req_next        = s_data;
            res_status_next = ST_DONE;
            res_first_next  = 8'd0;
            res_freed_next  = 9'd0;
        end

        if (cmd.scan_start) begin
            mode_next      = cmd.scan_mode;
            scanning_next  = 1'b1;
            run_next       = '0;
            run_start_next = '0;
            case (cmd.scan_mode)
                MODE_PLACE: begin
                    rd_idx_next = CNT_W'(req_reg.start_block);
                    limit_next  = place_end[CNT_W-1:0];
                end
                MODE_DELETE: begin
                    rd_idx_next = '0;
                    limit_next  = CNT_W'(DISK_BLOCKS);
                end
                default: begin
                    rd_idx_next = '0;
                    limit_next  = eff_size;
                end
            endcase
        end else if (scanning_reg) begin
            if (issue) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            p_vld_next    = issue && !scan_done;
            scanning_next = !scan_done;
            if (p_vld_reg && (mode_reg == MODE_CREATE)) begin
                if (ent_used) begin
                    run_next       = '0;
                    run_start_next = CNT_W'(p_idx_reg) + CNT_W'(1);
                end else begin
                    run_next = run_inc;
                end
            end
            if (del_match && (res_freed_reg != 9'h1FF)) begin
                res_freed_next = res_freed_reg + 9'd1;
            end
        end

        if (cmd.claim_start) begin
            claiming_next  = 1'b1;
            wr_idx_next    = claim_base;
            wr_end_next    = claim_base + CNT_W'(req_reg.block_count);
            res_first_next = claim_base[7:0];
        end else if (claiming_reg) begin
            wr_idx_next   = wr_idx_reg + CNT_W'(1);
            claiming_next = !claim_done;
        end

        if (ram_we) begin
            ent_vld_next[ram_waddr] = 1'b1;
        end

        if (cmd.status_we) begin
            res_status_next = cmd.status_code;
        end

        if (cmd.emit) begin
            m_valid_next                = 1'b1;
            m_data_next.status          = res_status_reg;
            m_data_next.first_block_out = res_first_reg;
            m_data_next.freed_count     = res_freed_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_size_reg <= DISK_SIZE_RESET;
            scanning_reg  <= 1'b0;
            p_vld_reg     <= 1'b0;
            claiming_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            ent_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            disk_size_reg <= disk_size_next;
            scanning_reg  <= scanning_next;
            p_vld_reg     <= p_vld_next;
            claiming_reg  <= claiming_next;
            m_valid_reg   <= m_valid_next;
            ent_vld_reg   <= ent_vld_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        mode_reg       <= mode_next;
        rd_idx_reg     <= rd_idx_next;
        limit_reg      <= limit_next;
        p_idx_reg      <= p_idx_next;
        run_reg        <= run_next;
        run_start_reg  <= run_start_next;
        wr_idx_reg     <= wr_idx_next;
        wr_end_reg     <= wr_end_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_freed_reg  <= res_freed_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/cba_ctrl.sv
module cba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cba_pkg::cba_sts_t sts,
    output cba_pkg::cba_cmd_t cmd
);

    import cba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_CLAIM  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd.load        = 1'b0;
        cmd.scan_start  = 1'b0;
        cmd.scan_mode   = MODE_CREATE;
        cmd.claim_start = 1'b0;
        cmd.status_we   = 1'b0;
        cmd.status_code = ST_DONE;
        cmd.emit        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.action)
                    ACT_CREATE: begin
                        if (sts.len_zero) begin
                            state_next = S_FINISH;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = MODE_CREATE;
                            state_next     = S_SCAN;
                        end
                    end
                    ACT_DELETE: begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = MODE_DELETE;
                        state_next     = S_SCAN;
                    end
                    ACT_PLACE: begin
                        if (sts.len_zero) begin
                            state_next = S_FINISH;
                        end else if (!sts.place_in_range) begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_REFUSED;
                            state_next      = S_FINISH;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = MODE_PLACE;
                            state_next     = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = ST_REFUSED;
                        state_next      = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.action == ACT_DELETE) begin
                        state_next = S_FINISH;
                    end else if (sts.scan_ok) begin
                        cmd.claim_start = 1'b1;
                        state_next      = S_CLAIM;
                    end else begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = (sts.action == ACT_CREATE) ? ST_NO_SPACE
                                                                     : ST_REFUSED;
                        state_next      = S_FINISH;
                    end
                end
            end
            S_CLAIM: begin
                if (sts.claim_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/contiguous_block_allocator.sv
// Channel    Direction  Handshake            Payload
// s_         in         s_valid / s_ready    cba_req_t: action, tag, count, start
// m_         out        m_valid / m_ready    cba_rsp_t: status, first block, freed
// cfg_       in         cfg_valid/cfg_ready  disk size in use, 9 bits
//
// One request is worked at a time; a new transfer is taken once the previous
// result sits in the output register, even if that result is still stalled.
// Create, place and delete each scan the tag store through its single read
// port, one block per cycle. Reset is synchronous and leaves every block
// free at once through per-entry valid flops, so no clearing pass follows
// reset.

module contiguous_block_allocator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cba_pkg::cba_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cba_pkg::cba_rsp_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [8:0]        cfg_data
);

    import cba_pkg::*;

    // The controller sequences decode, scan, claim and result hand-off; the
    // datapath owns the block store, the scan pipeline and the output register.
    cba_cmd_t cmd;
    cba_sts_t sts;

    cba_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // The datapath latches the request when the controller accepts the
    // transfer, so s_data is only sampled on that edge.
    cba_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: rtl/core/cba_checker.sv
`include "assert_macros.svh"

module cba_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cba_pkg::cba_rsp_t m_data
);

    import cba_pkg::*;

    logic first_zero;
    logic none_freed;

    assign first_zero = (m_data.first_block_out == 8'd0);
    assign none_freed = (m_data.freed_count == 9'd0);

    // Only one request is in work: an accepted transfer closes the input.
    `AST_DEF(a_one_in_work, (s_valid && s_ready) |=> !s_ready)

    // A refused or failed request never reports a claimed run or freed blocks.
    `AST_DEF(a_fail_clean, (m_valid && (m_data.status != ST_DONE)) |-> (first_zero && none_freed))

    // Freed blocks are reported only by a delete, which always completes.
    `AST_DEF(a_freed_done, (m_valid && !none_freed) |-> ((m_data.status == ST_DONE) && first_zero))

    // A stalled result holds.
    `AST_DEF(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (.*);

FILE: dv/contiguous_block_allocator_tb.sv
module contiguous_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cba_pkg::*;

    // Action code 3 has no meaning in the package, but the field allows it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // The limit covers the longest create, with len up to 511, plus the
    // longest receiver stall and the longest sender gap, and then that
    // several times over.
    localparam int IDLE_LIMIT  = 4000;
    // Wait this long after the last result, so that nothing extra comes.
    localparam int TAIL_CYCLES = 800;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    cba_req_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    cba_rsp_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data  = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    contiguous_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the disk: one used bit and one owner tag per block,
    // plus the disk size register as last written.
    bit         blk_used  [DISK_BLOCKS];
    logic [7:0] blk_owner [DISK_BLOCKS];
    logic [8:0] size_in_use;

    // Predicted responses, oldest first, one per accepted request.
    cba_rsp_t   pending_alloc_rsp [$];

    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    // Percent chance per request of a sender gap, and per cycle of a
    // receiver stall. The directed part and each later phase set their own.
    int         gap_pct        = 0;
    int         stall_pct      = 0;
    int         stall_left     = 0;
    // True while s_valid has been raised and not yet dropped by us. This
    // keeps s_valid to at most one nonblocking assignment per time step.
    bit         input_held     = 1'b0;
    // A handful of owner tags per phase, so that deletes really free blocks.
    logic [7:0] tag_pool [6];

    // The blocks that may be claimed: the register, clipped at the depth.
    function automatic int eff_blocks();
        return (size_in_use > DISK_BLOCKS) ? DISK_BLOCKS : int'(size_in_use);
    endfunction

    function automatic void claim_blocks(input int first, input int len, input logic [7:0] tag);
        for (int k = first; k < first + len && k < DISK_BLOCKS; k++) begin
            blk_used[k]  = 1'b1;
            blk_owner[k] = tag;
        end
    endfunction

    // Works out the response to one request and updates our copy of the disk
    // the way the allocator must.
    function automatic cba_rsp_t predict_alloc(input cba_req_t rq);
        cba_rsp_t rs;
        int       lim;
        int       len;
        int       first;
        int       run;
        int       run_first;
        int       freed;
        bit       found;
        bit       fits;
        rs        = '0;
        lim       = eff_blocks();
        len       = int'(rq.block_count);
        first     = int'(rq.start_block);
        run       = 0;
        run_first = 0;
        freed     = 0;
        found     = 1'b0;
        fits      = 1'b0;
        case (rq.action)
            ACT_CREATE: begin
                // First fit: the lowest run of free blocks that is long enough.
                // A zero length claims nothing and still reports done.
                if (len != 0) begin
                    for (int k = 0; k < lim && !found; k++) begin
                        if (blk_used[k]) begin
                            run       = 0;
                            run_first = k + 1;
                        end else begin
                            run++;
                            if (run == len) begin
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        claim_blocks(run_first, len, rq.file_tag);
                        rs.first_block_out = 8'(run_first);
                    end else begin
                        rs.status = ST_NO_SPACE;
                    end
                end
            end
            ACT_DELETE: begin
                // Delete looks at the whole store, also past the disk size.
                for (int k = 0; k < DISK_BLOCKS; k++) begin
                    if (blk_used[k] && blk_owner[k] == rq.file_tag) begin
                        blk_used[k]  = 1'b0;
                        blk_owner[k] = FREE_TAG;
                        if (freed < 511) begin
                            freed++;
                        end
                    end
                end
                rs.freed_count = 9'(freed);
            end
            ACT_PLACE: begin
                // The run must end inside the disk and touch no used block.
                if (len != 0) begin
                    fits = (first + len <= lim);
                    for (int k = first; fits && k < first + len; k++) begin
                        if (blk_used[k]) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        claim_blocks(first, len, rq.file_tag);
                        rs.first_block_out = 8'(first);
                    end else begin
                        rs.status = ST_REFUSED;
                    end
                end
            end
            default: begin
                // The unused action code changes nothing and is refused.
                rs.status = ST_REFUSED;
            end
        endcase
        return rs;
    endfunction

    function automatic cba_req_t req_of(input logic [1:0] act, input logic [7:0] tag,
                                        input logic [8:0] cnt, input logic [7:0] first);
        cba_req_t rq;
        rq.action      = act;
        rq.file_tag    = tag;
        rq.block_count = cnt;
        rq.start_block = first;
        return rq;
    endfunction

    // Request lengths: mostly short runs, now and then zero, the whole disk,
    // or any 9-bit value at all, which also covers lengths past the depth.
    function automatic logic [8:0] pick_count(input int lim);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 9'd0;
        end else if (r == 1) begin
            return 9'($urandom);
        end else if (r == 2) begin
            return 9'(lim);
        end else if (r < 12) begin
            return 9'($urandom_range(1, 8));
        end
        return 9'($urandom_range(1, lim / 4 + 1));
    endfunction

    // Random requests. Most are well-formed creates, deletes and places on
    // the current tag pool; places are often aimed at a free block so that
    // they can succeed. The rest are unused action codes and raw noise.
    function automatic cba_req_t rand_req();
        cba_req_t rq;
        int       lim;
        int       pick;
        int       k;
        lim = eff_blocks();
        rq  = cba_req_t'(27'($urandom));
        if ($urandom_range(0, 9) != 0) begin
            rq.file_tag = tag_pool[$urandom_range(0, 5)];
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            rq.action      = ACT_CREATE;
            rq.block_count = pick_count(lim);
        end else if (pick < 58) begin
            rq.action = ACT_DELETE;
        end else if (pick < 88) begin
            rq.action      = ACT_PLACE;
            rq.block_count = pick_count(lim);
            k = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
            if ($urandom_range(0, 1) == 1) begin
                while (k < lim - 1 && blk_used[k]) begin
                    k++;
                end
            end
            rq.start_block = 8'(k);
        end else if (pick < 93) begin
            rq.action = ACT_UNUSED;
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Drops s_valid, if it is up, so that no request is presented.
    task automatic release_input();
        if (input_held) begin
            s_valid    <= 1'b0;
            input_held  = 1'b0;
        end
    endtask

    // Presents one request, holds it until the transfer, and then records
    // the predicted response. s_valid stays high on return, so that a
    // request that follows at once is presented without a gap.
    task automatic send_req(input cba_req_t rq);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            release_input();
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= rq;
        input_held  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_alloc_rsp.insert(pending_alloc_rsp.size(), predict_alloc(rq));
    endtask

    // Stops sending and waits until every predicted response has arrived.
    // With no request presented and every result delivered, the allocator
    // is idle once this returns.
    task automatic drain_results();
        release_input();
        while (pending_alloc_rsp.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One transfer on the configuration channel. Callers drain first.
    task automatic write_disk_size(input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        size_in_use  = value;
    endtask

    task automatic refresh_tag_pool();
        foreach (tag_pool[i]) begin
            tag_pool[i] = 8'($urandom);
        end
        // Now and then one of the files carries the free mark as its tag.
        if ($urandom_range(0, 3) == 0) begin
            tag_pool[0] = FREE_TAG;
        end
    endtask

    // Receiver side: m_ready drops in bursts of random length, as often as stall_pct sets.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Response checker. Every transfer on the result channel is matched
    // against the oldest prediction, field by field.
    always @(posedge aclk) begin
        cba_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_alloc_rsp.size() == 0) begin
                report_mismatch("response with no request pending", int'(m_data), -1);
            end else begin
                want = pending_alloc_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    report_mismatch("status", int'(m_data.status), int'(want.status));
                end
                if (m_data.first_block_out !== want.first_block_out) begin
                    report_mismatch("first_block_out", int'(m_data.first_block_out),
                                    int'(want.first_block_out));
                end
                if (m_data.freed_count !== want.freed_count) begin
                    report_mismatch("freed_count", int'(m_data.freed_count),
                                    int'(want.freed_count));
                end
            end
        end
    end

    // Watchdog: a run of cycles with no transfer on any channel means the
    // allocator has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[contiguous_block_allocator] ERROR");
            $finish;
        end
    end

    // First fit on the full default disk: zero length, a run at the bottom,
    // the rest of the disk, and then a request that cannot fit.
    task automatic test_create_first_fit();
        send_req(req_of(ACT_CREATE, "A", 9'd0, 8'd0));
        send_req(req_of(ACT_CREATE, "A", 9'd10, 8'h5A));
        send_req(req_of(ACT_CREATE, "B", 9'd246, 8'd0));
        send_req(req_of(ACT_CREATE, "C", 9'd1, 8'd0));
    endtask

    // Deleting frees a hole; a create one block too long still fails, one
    // that fits exactly lands in the hole.
    task automatic test_delete_by_tag();
        send_req(req_of(ACT_DELETE, "A", 9'd0, 8'd0));
        send_req(req_of(ACT_DELETE, "Z", 9'd0, 8'd0));
        send_req(req_of(ACT_CREATE, "C", 9'd11, 8'd0));
        send_req(req_of(ACT_CREATE, "C", 9'd10, 8'd0));
    endtask

    // Place at the last block, past the end, over a used run, with zero
    // length, into the free gap, and with the largest length the field holds.
    task automatic test_place_rules();
        send_req(req_of(ACT_DELETE, "B", 9'd0, 8'd0));
        send_req(req_of(ACT_PLACE, "D", 9'd1, 8'd255));
        send_req(req_of(ACT_PLACE, "D", 9'd2, 8'd255));
        send_req(req_of(ACT_PLACE, "E", 9'd10, 8'd5));
        send_req(req_of(ACT_PLACE, "E", 9'd0, 8'd200));
        send_req(req_of(ACT_PLACE, "E", 9'd245, 8'd10));
        send_req(req_of(ACT_PLACE, 8'hFF, 9'h1FF, 8'd0));
    endtask

    // Action code 3 must leave the disk alone and be refused.
    task automatic test_unused_action();
        send_req(req_of(ACT_UNUSED, 8'hFF, 9'h1FF, 8'hFF));
        send_req(req_of(ACT_UNUSED, 8'h00, 9'd0, 8'd0));
    endtask

    // Disk size at one block, at zero, and above the depth. A delete must
    // still find blocks that lie past a shrunken disk.
    task automatic test_size_limits();
        send_req(req_of(ACT_DELETE, "C", 9'd0, 8'd0));
        send_req(req_of(ACT_DELETE, "D", 9'd0, 8'd0));
        send_req(req_of(ACT_DELETE, "E", 9'd0, 8'd0));
        drain_results();
        write_disk_size(9'd1);
        send_req(req_of(ACT_CREATE, 8'h00, 9'd1, 8'd0));
        send_req(req_of(ACT_CREATE, 8'h00, 9'd1, 8'd0));
        drain_results();
        write_disk_size(9'd0);
        send_req(req_of(ACT_CREATE, 8'hFF, 9'd1, 8'd0));
        send_req(req_of(ACT_DELETE, 8'h00, 9'd0, 8'd0));
        drain_results();
        write_disk_size(9'h1FF);
        send_req(req_of(ACT_CREATE, 8'hFF, 9'd256, 8'd0));
        send_req(req_of(ACT_DELETE, 8'hFF, 9'd0, 8'd0));
    endtask

    // Random traffic in phases, each with its own disk size, tag pool and
    // amount of idling. The sizes include both extremes and values above
    // the depth. In some phases the sender stops halfway until every
    // response is back.
    task automatic test_random_traffic();
        logic [8:0] sizes [10];
        int         levels [4];
        sizes  = '{9'd256, 9'd1, 9'h1FF, 9'd37, 9'd0, 9'd2, 9'd255, 9'd128, 9'd300, 9'd200};
        levels = '{0, 10, 30, 60};
        sizes[7] = 9'($urandom_range(3, 254));
        sizes[8] = 9'($urandom_range(257, 511));
        sizes[9] = 9'($urandom_range(1, 256));
        for (int p = 0; p < 10; p++) begin
            drain_results();
            write_disk_size(sizes[p]);
            gap_pct   = levels[$urandom_range(0, 3)];
            stall_pct = levels[$urandom_range(0, 3)];
            refresh_tag_pool();
            for (int n = 0; n < 105; n++) begin
                if (n == 52 && p % 3 == 0) begin
                    drain_results();
                end
                send_req(rand_req());
            end
        end
    endtask

    // Last stretch: back-to-back requests with the receiver always ready.
    task automatic test_steady_stream();
        drain_results();
        write_disk_size(9'($urandom_range(64, 256)));
        gap_pct   = 0;
        stall_pct = 0;
        refresh_tag_pool();
        for (int n = 0; n < 120; n++) begin
            send_req(rand_req());
        end
    endtask

    initial begin
        foreach (blk_used[k]) begin
            blk_used[k]  = 1'b0;
            blk_owner[k] = FREE_TAG;
        end
        size_in_use = DISK_SIZE_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed part runs with light idling on both sides.
        gap_pct   = 30;
        stall_pct = 20;
        test_create_first_fit();
        test_delete_by_tag();
        test_place_rules();
        test_unused_action();
        test_size_limits();
        test_random_traffic();
        test_steady_stream();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_alloc_rsp.size() == 0) begin
            $display("[contiguous_block_allocator] OK");
        end else begin
            $display("[contiguous_block_allocator] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cba_pkg.sv
rtl/core/cba_ram.sv
rtl/core/cba_datapath.sv
rtl/core/cba_ctrl.sv
rtl/core/contiguous_block_allocator.sv
rtl/core/cba_checker.sv
dv/contiguous_block_allocator_tb.sv
